>>> sv/emre_pkg.sv
package emre_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] ref_base;
        logic [7:0] obs_base;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_in_run;
        logic       bad_symbol;
        logic       pending_overflow;
    } t_out_item;

    // classified command between front and back
    typedef struct packed {
        logic       flush;
        logic       bad;
        logic [1:0] ctx;
        logic [1:0] sym;
    } t_cmd;

    localparam int RES_LIMIT = 40;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;

    function automatic logic [1:0] map_base(input logic [7:0] c);
        logic [1:0] v;
        v = 2'd3;
        if (c == CH_A) v = 2'd0;
        else if (c == CH_C) v = 2'd1;
        else if (c == CH_G) v = 2'd2;
        return v;
    endfunction

endpackage

>>> sv/emre_front.sv
module emre_front import emre_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);
    // two-entry queue of classified commands
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    t_cmd       w_cmd;
    logic [1:0] w_r, w_o;
    logic       w_push, w_pop;

    always_comb begin
        w_r = map_base(i_item.ref_base);
        w_o = map_base(i_item.obs_base);
        w_cmd.flush = i_item.op;
        w_cmd.bad   = !i_item.op && (w_r == w_o);
        w_cmd.ctx   = w_r;
        w_cmd.sym   = (w_o > w_r) ? w_o - 2'd1 : w_o;
    end

    assign o_full      = r_cnt[1];
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign w_pop       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cmd;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overrun");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_pop) |=> o_full) else $error("full dropped without pop");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid) else $error("valid while empty");
endmodule

>>> sv/emre_div.sv
module emre_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    // restoring divider, one quotient bit a cycle
    logic [31:0] r_q;
    logic [17:0] r_rem;
    logic [5:0]  r_n;
    logic        r_busy;
    logic [17:0] w_t;

    assign w_t    = {r_rem[16:0], r_q[31]};
    assign o_quo  = r_q;
    assign o_done = r_busy && r_n == 6'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_n    <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_n    <= 6'd32;
            r_q    <= i_num;
            r_rem  <= 18'd0;
        end else if (r_busy) begin
            if (r_n == 6'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_n <= r_n - 6'd1;
                if (w_t >= {1'b0, i_den}) begin
                    r_rem <= w_t - {1'b0, i_den};
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_t;
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
        end
    end
endmodule

>>> sv/emre_back.sv
module emre_back import emre_pkg::*; #(
    parameter int MAX_PENDING = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_NORM  = 9'b000001000,
        S_SHIFT = 9'b000010000,
        S_EMIT  = 9'b000100000,
        S_FREQ  = 9'b001000000,
        S_FLAG  = 9'b010000000,
        S_CLR   = 9'b100000000
    } t_state;

    t_state      r_st;
    logic [16:0] r_f [12];
    logic [32:0] r_low;
    logic [31:0] r_range;
    logic [7:0]  r_cache;
    logic [5:0]  r_pend;
    t_cmd        r_cmd;
    logic [2:0]  r_nflush;
    logic [5:0]  r_nout;
    logic [5:0]  r_emit_i;
    logic        r_carry;
    logic [7:0]  r_new_cache;
    logic        r_ovf;
    logic [16:0] r_tot;
    logic [16:0] r_cum;
    logic [16:0] r_wid;
    logic [7:0]  r_hold;
    logic        r_hold_v;
    logic        r_ovalid;
    t_out_item   r_oitem;

    logic        w_div_done;
    logic [31:0] w_quo;
    logic [3:0]  w_base;
    logic [16:0] w_f0, w_f1, w_f2;
    logic [17:0] w_tot18;
    logic        w_out_free;
    logic        w_emit_last;
    logic        w_emit_go;
    logic        w_keep;
    logic [7:0]  w_byte;
    logic        w_load;
    t_out_item   w_litem;
    logic [16:0] w_fnew [3];

    assign w_base  = {r_cmd.ctx, 2'b00} - {2'b00, r_cmd.ctx};
    assign w_f0    = r_f[w_base];
    assign w_f1    = r_f[w_base + 4'd1];
    assign w_f2    = r_f[w_base + 4'd2];
    assign w_tot18 = {1'b0, w_f0} + {1'b0, w_f1} + {1'b0, w_f2};

    assign o_empty     = !r_ovalid;
    assign o_item      = r_oitem;
    assign w_out_free  = !r_ovalid || i_pop;
    assign o_cmd_take  = (r_st == S_IDLE) && i_cmd_valid && w_out_free;
    assign w_emit_last = r_emit_i + 6'd1 >= r_pend;
    assign w_emit_go   = !r_hold_v || w_out_free;
    assign w_keep      = r_nout < 6'(RES_LIMIT);
    assign w_byte      = (r_emit_i == 6'd0) ? r_cache + {7'd0, r_carry}
                                            : 8'hFF + {7'd0, r_carry};

    // newest byte waits in r_hold until the next one shows whether it is last
    always_comb begin
        w_load  = 1'b0;
        w_litem = '0;
        if (r_st == S_IDLE && o_cmd_take && i_cmd.bad) begin
            w_load  = 1'b1;
            w_litem = '{8'd0, 1'b1, 1'b1, 1'b0};
        end else if (r_st == S_EMIT && w_emit_go && w_keep && r_hold_v) begin
            w_load  = 1'b1;
            w_litem = '{r_hold, 1'b0, 1'b0, 1'b0};
        end else if (r_st == S_FLAG && w_out_free) begin
            if (r_ovf && r_hold_v && w_keep) begin
                w_load  = 1'b1;
                w_litem = '{r_hold, 1'b0, 1'b0, 1'b0};
            end else if (r_ovf) begin
                w_load  = 1'b1;
                w_litem = '{8'd0, 1'b1, 1'b0, 1'b1};
            end else if (r_hold_v) begin
                w_load  = 1'b1;
                w_litem = '{r_hold, 1'b1, 1'b0, 1'b0};
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_fnew[j] = r_f[w_base + 4'(j)];
            if (j == int'(r_cmd.sym)) w_fnew[j] = w_fnew[j] + 17'd8;
            if ({1'b0, r_tot} + 18'd8 > 18'd65536) w_fnew[j] = (w_fnew[j] >> 1) | 17'd1;
        end
    end

    emre_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_st == S_DIV && r_nflush == 3'd7),
        .i_num  (r_range),
        .i_den  (r_tot),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_ovalid <= 1'b0;
            r_hold_v <= 1'b0;
            r_pend   <= 6'd1;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !i_pop);
            if (w_load) r_oitem <= w_litem;
            unique case (r_st)
                S_CLR: begin
                    for (int i = 0; i < 12; i++) r_f[i] <= 17'd1;
                    r_low   <= 33'd0;
                    r_range <= '1;
                    r_cache <= 8'd0;
                    r_pend  <= 6'd1;
                    r_st    <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd  <= i_cmd;
                        r_nout <= 6'd0;
                        r_ovf  <= 1'b0;
                        if (i_cmd.flush) begin
                            r_nflush <= 3'd5;
                            r_st     <= S_SHIFT;
                        end else if (!i_cmd.bad) begin
                            r_nflush <= 3'd7;
                            r_st     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_nflush == 3'd7) begin
                        r_tot    <= w_tot18[16:0];
                        r_nflush <= 3'd0;
                        unique case (r_cmd.sym)
                            2'd0: begin r_cum <= 17'd0; r_wid <= w_f0; end
                            2'd1: begin r_cum <= w_f0; r_wid <= w_f1; end
                            default: begin r_cum <= w_f0 + w_f1; r_wid <= w_f2; end
                        endcase
                    end
                    if (w_div_done) begin
                        r_range <= w_quo;
                        r_st    <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_low   <= r_low + 33'(48'(r_cum) * 48'(r_range));
                    r_range <= 32'(48'(r_range) * 48'(r_wid));
                    r_st    <= S_NORM;
                end
                S_NORM: begin
                    if (r_range < 32'h0100_0000) begin
                        r_range <= {r_range[23:0], 8'd0};
                        r_st    <= S_SHIFT;
                    end else begin
                        r_st <= S_FREQ;
                    end
                end
                S_SHIFT: begin
                    r_carry     <= r_low[32];
                    r_new_cache <= r_low[31:24];
                    r_low       <= {1'b0, r_low[23:0], 8'd0};
                    if (r_cmd.flush) r_nflush <= r_nflush - 3'd1;
                    if (r_low[32] || r_low[31:0] < 32'hFF00_0000) begin
                        r_emit_i <= 6'd0;
                        r_st     <= S_EMIT;
                    end else begin
                        if (r_pend >= 6'(MAX_PENDING)) begin
                            r_pend <= 6'(MAX_PENDING);
                            r_ovf  <= 1'b1;
                        end else begin
                            r_pend <= r_pend + 6'd1;
                        end
                        r_st <= r_cmd.flush ? ((r_nflush == 3'd1) ? S_FLAG : S_SHIFT)
                                            : S_NORM;
                    end
                end
                S_EMIT: begin
                    if (w_emit_go) begin
                        if (w_keep) begin
                            r_hold   <= w_byte;
                            r_hold_v <= 1'b1;
                            r_nout   <= r_nout + 6'd1;
                        end
                        r_emit_i <= r_emit_i + 6'd1;
                        if (w_emit_last) begin
                            r_cache <= r_new_cache;
                            r_pend  <= 6'd1;
                            if (r_cmd.flush)
                                r_st <= (r_nflush == 3'd0) ? S_FLAG : S_SHIFT;
                            else
                                r_st <= S_NORM;
                        end
                    end
                end
                S_FREQ: begin
                    for (int j = 0; j < 3; j++) r_f[w_base + 4'(j)] <= w_fnew[j];
                    r_st <= S_FLAG;
                end
                S_FLAG: begin
                    // held byte goes out first when an overflow flag follows it
                    if (w_out_free) begin
                        r_hold_v <= 1'b0;
                        if (!(r_ovf && r_hold_v && w_keep))
                            r_st <= r_cmd.flush ? S_CLR : S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 6'(MAX_PENDING)) else $error("pending run over bound");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_st == S_IDLE) else $error("take outside idle");
    a_range_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FREQ) |-> r_range >= 32'h0100_0000) else $error("range not normalized");
endmodule

>>> sv/exclusive_mismatch_range_encoder.sv
// A coded mismatch holds the coder through the serial divider and the multiply,
// then a shift per range shift and an emit per byte, and a further step when an
// overflow flag follows a byte; a flush shifts and emits its bytes; an equal-base
// item is answered in idle. The coder holds one item, with two commands queued ahead.
// Reset: synchronous active low; a clearing pass in S_CLR sets every count to 1,
// range to all ones, low and cache to 0 and the pending run to 1.
module exclusive_mismatch_range_encoder import emre_pkg::*; #(
    parameter int MAX_PENDING = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);
    logic w_valid, w_take;
    t_cmd w_cmd;
    t_out_item w_raw;
    logic w_empty;

    emre_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_item), .o_cmd_valid(w_valid), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    emre_back #(.MAX_PENDING(MAX_PENDING)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_take), .o_empty(w_empty), .i_pop(pop), .o_item(w_raw)
    );

    assign empty  = w_empty;
    assign o_item = w_raw;
endmodule

>>> sim/tb_exclusive_mismatch_range_encoder.sv
module tb_exclusive_mismatch_range_encoder;
    import emre_pkg::*;

    localparam int          MAX_PEND  = 32;
    localparam logic        OP_CODE   = 1'b0;
    localparam logic        OP_FLUSH  = 1'b1;
    localparam logic [7:0]  CH_T      = 8'h54;
    localparam int          WD_LIMIT  = 8000;
    localparam int          HOLD_LEN  = 800;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;

    exclusive_mismatch_range_encoder #(.MAX_PENDING(MAX_PEND)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    // coder copy
    int unsigned  freq [4][3];
    logic [32:0]  low_acc;
    logic [31:0]  span;
    logic [7:0]   cache;
    int unsigned  pend_run;
    logic [7:0]   byte_buf [$];
    bit           ovf_hit;

    t_in_item  stim_q   [$];
    bit        drain_q  [$];
    t_out_item byte_q   [$];

    bit  offering;
    bit  stim_done;
    int  gap_cnt;
    int  pop_gap;
    int  hold_cnt;
    bit  hold_done;
    int  n_in;
    int  n_out;
    int  n_flush;
    int  n_bad;
    int  n_ovf;
    int  n_fail;
    int  idle_cnt;
    longint cyc;

    task automatic coder_reset();
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 3; k++)
                freq[r][k] = 1;
        low_acc  = '0;
        span     = 32'hFFFF_FFFF;
        cache    = '0;
        pend_run = 1;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        if (byte_buf.size() < RES_LIMIT)
            byte_buf.insert(byte_buf.size(), b);
    endtask

    task automatic shift_low();
        logic [31:0] lo32;
        logic        carry;
        lo32  = low_acc[31:0];
        carry = low_acc[32];
        if (carry || lo32 < 32'hFF00_0000) begin
            emit_byte(cache + {7'd0, carry});
            for (int unsigned i = 1; i < pend_run; i++)
                emit_byte(8'hFF + {7'd0, carry});
            cache    = lo32[31:24];
            pend_run = 1;
        end else if (pend_run >= MAX_PEND) begin
            pend_run = MAX_PEND;
            ovf_hit  = 1;
        end else begin
            pend_run++;
        end
        low_acc = {1'b0, lo32 << 8};
    endtask

    task automatic encode_item(input t_in_item it);
        logic [1:0]      r, o, k;
        int unsigned     tot, cum, width;
        logic [63:0]     sum;
        t_out_item       res;
        int              n;
        byte_buf.delete();
        ovf_hit = 0;
        if (it.op == OP_FLUSH) begin
            n_flush++;
            for (int i = 0; i < 5; i++)
                shift_low();
            coder_reset();
        end else begin
            r = map_base(it.ref_base);
            o = map_base(it.obs_base);
            if (r == o) begin
                n_bad++;
                res = '{byte_value: 8'd0, last_in_run: 1'b1, bad_symbol: 1'b1,
                        pending_overflow: 1'b0};
                byte_q.insert(byte_q.size(), res);
                return;
            end
            k = (o > r) ? o - 2'd1 : o;
            tot = freq[r][0] + freq[r][1] + freq[r][2];
            cum = 0;
            for (int j = 0; j < k; j++)
                cum += freq[r][j];
            width = freq[r][k];
            span = span / tot;
            sum = {31'd0, low_acc} + 64'(cum) * 64'(span);
            low_acc = sum[32:0];
            span = span * width;
            while (span < 32'h0100_0000) begin
                span = span << 8;
                shift_low();
            end
            freq[r][k] += 8;
            if (tot + 8 > 65536)
                for (int j = 0; j < 3; j++)
                    freq[r][j] = (freq[r][j] >> 1) | 1;
        end
        n = byte_buf.size();
        foreach (byte_buf[i]) begin
            res = '{byte_value: byte_buf[i], last_in_run: 1'b0, bad_symbol: 1'b0,
                    pending_overflow: 1'b0};
            if (i == n - 1 && !ovf_hit)
                res.last_in_run = 1'b1;
            if (!(ovf_hit && n >= RES_LIMIT && i == RES_LIMIT - 1))
                byte_q.insert(byte_q.size(), res);
        end
        if (ovf_hit) begin
            n_ovf++;
            res = '{byte_value: 8'd0, last_in_run: 1'b1, bad_symbol: 1'b0,
                    pending_overflow: 1'b1};
            byte_q.insert(byte_q.size(), res);
        end
    endtask

    function automatic logic [7:0] pick_base();
        int unsigned s;
        s = $urandom_range(0, 9);
        case (s)
            0, 1:    return CH_A;
            2, 3:    return CH_C;
            4, 5:    return CH_G;
            6, 7:    return CH_T;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic op, input logic [7:0] rb, input logic [7:0] ob,
                            input bit drain_first);
        t_in_item it;
        it.op       = op;
        it.ref_base = rb;
        it.obs_base = ob;
        stim_q.insert(stim_q.size(), it);
        drain_q.insert(drain_q.size(), drain_first);
    endtask

    function automatic int rand_gap();
        int unsigned s;
        if ((cyc % 600) < 120)
            return 0;
        s = $urandom_range(0, 19);
        if (s < 11)
            return 0;
        if (s < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // sender: transfer at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            encode_item(i_item);
            void'(stim_q.pop_front());
            void'(drain_q.pop_front());
            offering = 0;
            n_in++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (offering) begin
        end else if (gap_cnt > 0) begin
            gap_cnt--;
            push <= 1'b0;
        end else if (stim_q.size() > 0 && !(drain_q[0] && byte_q.size() > 0)) begin
            i_item   <= stim_q[0];
            push     <= 1'b1;
            offering = 1;
            gap_cnt  = rand_gap();
        end else begin
            push <= 1'b0;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            n_out++;
            if (byte_q.size() == 0) begin
                $error("unexpected result byte_value=%0h", o_item.byte_value);
                n_fail++;
            end else begin
                if (o_item.byte_value !== byte_q[0].byte_value) begin
                    $error("byte_value expected %0h actual %0h",
                           byte_q[0].byte_value, o_item.byte_value);
                    n_fail++;
                end
                if (o_item.last_in_run !== byte_q[0].last_in_run) begin
                    $error("last_in_run expected %0b actual %0b",
                           byte_q[0].last_in_run, o_item.last_in_run);
                    n_fail++;
                end
                if (o_item.bad_symbol !== byte_q[0].bad_symbol) begin
                    $error("bad_symbol expected %0b actual %0b",
                           byte_q[0].bad_symbol, o_item.bad_symbol);
                    n_fail++;
                end
                if (o_item.pending_overflow !== byte_q[0].pending_overflow) begin
                    $error("pending_overflow expected %0b actual %0b",
                           byte_q[0].pending_overflow, o_item.pending_overflow);
                    n_fail++;
                end
                void'(byte_q.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (!hold_done && n_in >= 20) begin
            hold_done = 1;
            hold_cnt  = HOLD_LEN;
            pop <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            pop_gap = rand_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("exclusive_mismatch_range_encoder verification failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] bases [4];
        logic [7:0] rb, ob;
        int unsigned s;
        bases = '{CH_A, CH_C, CH_G, CH_T};
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        cyc = 0;
        coder_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: flush of empty stream, every pair, equal bases, odd bytes
        add_item(OP_FLUSH, 8'h00, 8'h00, 0);
        for (int r = 0; r < 4; r++)
            for (int o = 0; o < 4; o++)
                add_item(OP_CODE, bases[r], bases[o], 0);
        add_item(OP_CODE, 8'hFF, 8'h00, 0);
        add_item(OP_CODE, 8'h00, CH_T, 0);
        add_item(OP_CODE, 8'hFF, CH_A, 0);
        add_item(OP_FLUSH, 8'hFF, 8'hFF, 0);
        add_item(OP_CODE, CH_G, 8'hFF, 1);
        add_item(OP_FLUSH, 8'h5A, 8'hA5, 0);

        // random streams
        for (int n = 0; n < 75; n++) begin
            s = $urandom_range(0, 19);
            rb = pick_base();
            ob = pick_base();
            if (s == 0)
                add_item(OP_FLUSH, 8'($urandom), 8'($urandom), 0);
            else if (s == 1)
                add_item(OP_CODE, rb, rb, 0);
            else
                add_item(OP_CODE, rb, ob, n == 60);
        end
        add_item(OP_FLUSH, 8'h00, 8'h00, 0);

        wait (stim_q.size() == 0 && !offering);
        wait (byte_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d items (%0d flushes, %0d equal-base) and %0d results",
                 n_in, n_flush, n_bad, n_out);
        $display("overflow flags predicted: %0d", n_ovf);
        if (n_fail == 0 && byte_q.size() == 0)
            $display("exclusive_mismatch_range_encoder verification clean");
        else
            $display("exclusive_mismatch_range_encoder verification failed");
        $finish;
    end

endmodule

>>> files.f
sv/emre_pkg.sv
sv/emre_front.sv
sv/emre_div.sv
sv/emre_back.sv
sv/exclusive_mismatch_range_encoder.sv
sim/tb_exclusive_mismatch_range_encoder.sv
